FILE: rtl/core/lpbw_pkg.sv
// ----------------------------------------------------------------------------
// lpbw_pkg
// Shared types, constants and the set-up command table of the page block
// writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbw_pkg;

  localparam int PANEL_COLUMNS_DEF = 128;
  localparam int PANEL_ROWS_DEF    = 32;

  localparam int PIX_W      = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int STATUS_W   = 2;
  localparam int STEP_W     = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_ADDR_W-1:0] CFG_START_PAGE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_COLUMN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_WIDTH    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BYTE_COUNT   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_SENT     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;

  localparam logic [3:0] ROWS_PER_BLOCK = 4'd8;
  localparam logic [7:0] PAGE_CMD_BASE  = 8'hB0;
  localparam logic [7:0] COL_HI_CMD     = 8'h10;
  localparam logic [STEP_W-1:0] SETUP_LAST = 4'd9;
  localparam logic [STEP_W-1:0] ROW_LAST   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_PAGE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_COL_HI = 4'd1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SETUP,
    BK_ROW,
    BK_FINAL
  } back_state_t;

  typedef struct packed {
    logic             rejected;
    logic             setup;
    logic             dropped;
    logic             row_start;
    logic [7:0]       page_cmd;
    logic [6:0]       start_column;
    logic [PIX_W-1:0] pixel_byte;
  } desc_t;

  function automatic logic [7:0] setup_cmd(input logic [STEP_W-1:0] idx);
    logic [7:0] cmd;
    case (idx)
      4'd0: cmd = 8'h2F;
      4'd1: cmd = 8'h24;
      4'd2: cmd = 8'h81;
      4'd3: cmd = 8'h1F;
      4'd4: cmd = 8'hA2;
      4'd5: cmd = 8'hC8;
      4'd6: cmd = 8'hA0;
      4'd7: cmd = 8'h40;
      4'd8: cmd = 8'hA6;
      4'd9: cmd = 8'hAF;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lpbw_pix_if.sv
// ----------------------------------------------------------------------------
// lpbw_pix_if
// Request channel that carries one display data byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpbw_pix_if import lpbw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lpbw_bus_if.sv
// ----------------------------------------------------------------------------
// lpbw_bus_if
// Request channel that carries one controller bus byte with its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpbw_bus_if import lpbw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [7:0]          bus_byte;
  logic                is_data;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output bus_byte, output is_data, output status,
                  output last, input ready);
  modport sink (input valid, input bus_byte, input is_data, input status,
                input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lpbw_cfg_if.sv
// ----------------------------------------------------------------------------
// lpbw_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpbw_cfg_if import lpbw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lpbw_front.sv
// ----------------------------------------------------------------------------
// lpbw_front
// Holds the registers and block state, classifies each data byte and
// pushes one descriptor per byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbw_front import lpbw_pkg::*; #(
  parameter int PANEL_COLUMNS = PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = PANEL_ROWS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpbw_pix_if.sink    in_if,
  lpbw_cfg_if.sink    cfg_if,
  input  wire logic   q_full,
  output logic        q_push,
  output desc_t       q_desc
);

  localparam int BlockLimit = PANEL_COLUMNS * PANEL_ROWS / 8;

  logic [2:0] start_page_r;
  logic [6:0] start_column_r;
  logic [7:0] row_width_r;
  logic [9:0] byte_count_r;

  logic       block_open_r, block_open_nxt;
  logic [9:0] bytes_sent_r, bytes_sent_nxt;
  logic [7:0] column_in_row_r, column_in_row_nxt;
  logic [3:0] row_index_r, row_index_nxt;

  logic       opening, rejected, drop, row_done, closing;
  logic [3:0] row_cur;
  logic [7:0] col_cur;
  logic [9:0] sent_cur, sent_inc, count_eff;
  logic [8:0] col_inc;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !q_full;
  assign q_push       = in_if.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_page_r   <= 3'd0;
      start_column_r <= 7'd0;
      row_width_r    <= 8'd128;
      byte_count_r   <= 10'd0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_START_PAGE:   start_page_r   <= cfg_if.data[2:0];
        CFG_START_COLUMN: start_column_r <= cfg_if.data[6:0];
        CFG_ROW_WIDTH:    row_width_r    <= cfg_if.data[7:0];
        CFG_BYTE_COUNT:   byte_count_r   <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    opening   = !block_open_r;
    row_cur   = opening ? 4'd0 : row_index_r;
    col_cur   = opening ? 8'd0 : column_in_row_r;
    sent_cur  = opening ? 10'd0 : bytes_sent_r;
    rejected  = 32'(byte_count_r) > 32'(BlockLimit);
    drop      = (row_width_r == 8'd0) || (row_cur >= ROWS_PER_BLOCK);
    col_inc   = {1'b0, col_cur} + 9'd1;
    row_done  = col_inc >= {1'b0, row_width_r};
    sent_inc  = sent_cur + 10'd1;
    count_eff = (byte_count_r == 10'd0) ? 10'd1 : byte_count_r;
    closing   = (sent_inc >= count_eff) || (sent_inc == 10'd0);

    block_open_nxt    = block_open_r;
    bytes_sent_nxt    = bytes_sent_r;
    column_in_row_nxt = column_in_row_r;
    row_index_nxt     = row_index_r;
    if (q_push && !rejected) begin
      block_open_nxt    = !closing;
      bytes_sent_nxt    = sent_inc;
      column_in_row_nxt = col_cur;
      row_index_nxt     = row_cur;
      if (!drop) begin
        if (row_done) begin
          column_in_row_nxt = 8'd0;
          row_index_nxt     = row_cur + 4'd1;
        end else begin
          column_in_row_nxt = col_inc[7:0];
        end
      end
    end

    q_desc.rejected     = rejected;
    q_desc.setup        = !rejected && opening;
    q_desc.dropped      = !rejected && drop;
    q_desc.row_start    = !rejected && !drop && (col_cur == 8'd0);
    q_desc.page_cmd     = PAGE_CMD_BASE + {5'd0, start_page_r} + {4'd0, row_cur};
    q_desc.start_column = start_column_r;
    q_desc.pixel_byte   = in_if.pixel_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_open_r    <= 1'b0;
      bytes_sent_r    <= 10'd0;
      column_in_row_r <= 8'd0;
      row_index_r     <= 4'd0;
    end else begin
      block_open_r    <= block_open_nxt;
      bytes_sent_r    <= bytes_sent_nxt;
      column_in_row_r <= column_in_row_nxt;
      row_index_r     <= row_index_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lpbw_queue.sv
// ----------------------------------------------------------------------------
// lpbw_queue
// Short descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbw_queue import lpbw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output logic       full,
  output logic       not_empty,
  output desc_t      head
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  desc_t             slots_r [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]     count_r, count_nxt;

  assign full      = count_r == (PtrW+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PtrW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lpbw_back.sv
// ----------------------------------------------------------------------------
// lpbw_back
// Expands each descriptor into set-up, row address and final bus bytes and
// drives them through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbw_back import lpbw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  wire desc_t head,
  output logic       pop,
  lpbw_bus_if.source out_if
);

  back_state_t         state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                adv, emit;
  logic [7:0]          emit_byte;
  logic                emit_data, emit_last;
  logic [STATUS_W-1:0] emit_status;

  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_data_r, out_last_r;
  logic [STATUS_W-1:0] out_status_r;

  assign adv = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      BK_IDLE: begin
        step_nxt = '0;
        if (head_valid) begin
          if (head.setup) begin
            state_nxt = BK_SETUP;
          end else if (head.row_start) begin
            state_nxt = BK_ROW;
          end else begin
            state_nxt = BK_FINAL;
          end
        end
      end
      BK_SETUP: begin
        if (adv) begin
          if (step_r == SETUP_LAST) begin
            step_nxt  = '0;
            state_nxt = head.row_start ? BK_ROW : BK_FINAL;
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end
      BK_ROW: begin
        if (adv) begin
          if (step_r == ROW_LAST) begin
            step_nxt  = '0;
            state_nxt = BK_FINAL;
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end
      BK_FINAL: begin
        if (adv) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    emit        = 1'b0;
    emit_byte   = 8'd0;
    emit_data   = 1'b0;
    emit_status = STATUS_SENT;
    emit_last   = 1'b0;
    pop         = 1'b0;
    case (state_r)
      BK_SETUP: begin
        emit      = adv;
        emit_byte = setup_cmd(step_r);
      end
      BK_ROW: begin
        emit = adv;
        if (step_r == STEP_PAGE) begin
          emit_byte = head.page_cmd;
        end else if (step_r == STEP_COL_HI) begin
          emit_byte = COL_HI_CMD | {5'd0, head.start_column[6:4]};
        end else begin
          emit_byte = {4'd0, head.start_column[3:0]};
        end
      end
      BK_FINAL: begin
        emit      = adv;
        pop       = adv;
        emit_last = 1'b1;
        if (head.rejected) begin
          emit_status = STATUS_REJECTED;
        end else if (head.dropped) begin
          emit_status = STATUS_DROPPED;
        end else begin
          emit_byte = head.pixel_byte;
          emit_data = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r   <= emit_byte;
      out_data_r   <= emit_data;
      out_status_r <= emit_status;
      out_last_r   <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.bus_byte = out_byte_r;
  assign out_if.is_data  = out_data_r;
  assign out_if.status   = out_status_r;
  assign out_if.last     = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/lcd_page_block_writer.sv
// ----------------------------------------------------------------------------
// lcd_page_block_writer
// Turns display data bytes into page-addressed controller bus bytes.
// ----------------------------------------------------------------------------
// Data bytes enter on in_if and bus bytes leave on out_if, each flagged as a
// command or display data byte, with a status and a last flag that marks the
// final result of each input byte. Registers are written on cfg_if, which is
// always ready, and should only change while the block is idle.
// The front part takes one byte per cycle while its four-entry descriptor
// queue has room. The back part sends one result per cycle while the receiver
// takes them, after passing through its idle state for each descriptor. Each
// byte ends in its final result, preceded by the page and column commands at
// the start of a row and by the set-up table at the start of a block.
// A taken byte is queued, and its results leave through the output register.
// When the receiver stalls, the output register holds its result, the back
// part waits, and the queue fills until in_if.ready falls.
// Reset clears the block state, the queue and the output register and
// loads the register defaults; no result is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_page_block_writer import lpbw_pkg::*; #(
  parameter int PANEL_COLUMNS = PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = PANEL_ROWS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpbw_pix_if.sink   in_if,
  lpbw_bus_if.source out_if,
  lpbw_cfg_if.sink   cfg_if
);

  logic  q_full, q_push, q_not_empty, q_pop;
  desc_t q_desc, q_head;

  lpbw_front #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (q_desc)
  );

  lpbw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lpbw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (q_head),
    .pop        (q_pop),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

FILE: verif/tb_lcd_page_block_writer.sv
// ----------------------------------------------------------------------------
// tb_lcd_page_block_writer
// Self-checking testbench for the page-addressed LCD block writer.
// ----------------------------------------------------------------------------
// Display bytes are sent through the input channel while a local model of the
// sequencer predicts every controller bus byte with its flags. Results are
// checked in order, field by field. Directed tests cover the register
// defaults, dropped and rejected bytes, the register extremes and a long
// output stall. Random blocks then run under several idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lcd_page_block_writer;
  import lpbw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_BYTES = PANEL_COLUMNS_DEF * PANEL_ROWS_DEF / 8;
  localparam int STALL_LIMIT = 3000;
  localparam int INIT_LEN = 10;
  localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{
    8'h2F, 8'h24, 8'h81, 8'h1F, 8'hA2, 8'hC8, 8'hA0, 8'h40, 8'hA6, 8'hAF
  };

  typedef struct packed {
    logic [7:0]          bus_byte;
    logic                is_data;
    logic [STATUS_W-1:0] status;
    logic                last;
  } bus_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lpbw_pix_if in_if ();
  lpbw_bus_if out_if ();
  lpbw_cfg_if cfg_if ();

  lcd_page_block_writer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the block state.
  logic [2:0] page_reg;
  logic [6:0] column_reg;
  logic [7:0] width_reg;
  logic [9:0] count_reg;
  logic       blk_open;
  logic [9:0] sent_cnt;
  logic [7:0] col_pos;
  logic [3:0] row_pos;

  bus_result_t bus_exp[$];

  int err_count = 0;
  int quiet_cycles = 0;
  int bytes_sent_tb = 0;
  int results_seen = 0;
  int rejected_seen = 0;
  int dropped_seen = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  function automatic void push_bus_byte(input logic [7:0] value, input logic data_flag,
                                        input logic [STATUS_W-1:0] st);
    bus_result_t r;
    r.bus_byte = value;
    r.is_data  = data_flag;
    r.status   = st;
    r.last     = 1'b0;
    bus_exp.push_back(r);
  endfunction

  function automatic void predict_bus_bytes(input logic [7:0] pix);
    int eff_count;
    bus_result_t tail;
    eff_count = (count_reg == 10'd0) ? 1 : int'(count_reg);
    if (int'(count_reg) > PANEL_BYTES) begin
      push_bus_byte(8'h00, 1'b0, STATUS_REJECTED);
    end else begin
      if (!blk_open) begin
        for (int i = 0; i < INIT_LEN; i++) push_bus_byte(INIT_SEQ[i], 1'b0, STATUS_SENT);
        blk_open = 1'b1;
        sent_cnt = '0;
        row_pos  = '0;
        col_pos  = '0;
      end
      if (width_reg == 8'd0 || row_pos >= ROWS_PER_BLOCK) begin
        push_bus_byte(8'h00, 1'b0, STATUS_DROPPED);
      end else begin
        if (col_pos == 8'd0) begin
          push_bus_byte(8'(PAGE_CMD_BASE + {5'b0, page_reg} + {4'b0, row_pos}), 1'b0,
                        STATUS_SENT);
          push_bus_byte(COL_HI_CMD | {5'b0, column_reg[6:4]}, 1'b0, STATUS_SENT);
          push_bus_byte({4'h0, column_reg[3:0]}, 1'b0, STATUS_SENT);
        end
        push_bus_byte(pix, 1'b1, STATUS_SENT);
        col_pos = col_pos + 8'd1;
        if (col_pos >= width_reg) begin
          col_pos = '0;
          row_pos = row_pos + 4'd1;
        end
      end
      sent_cnt = sent_cnt + 10'd1;
      if (int'(sent_cnt) >= eff_count || sent_cnt == 10'd0) blk_open = 1'b0;
    end
    tail = bus_exp.pop_back();
    tail.last = 1'b1;
    bus_exp.push_back(tail);
  endfunction

  function automatic void check_bus_byte();
    bus_result_t exp_r;
    if (bus_exp.size() == 0) begin
      $error("unexpected bus byte %0h", out_if.bus_byte);
      err_count++;
      return;
    end
    exp_r = bus_exp.pop_front();
    results_seen++;
    if (exp_r.status == STATUS_REJECTED) rejected_seen++;
    if (exp_r.status == STATUS_DROPPED) dropped_seen++;
    if (out_if.bus_byte !== exp_r.bus_byte) begin
      $error("bus_byte mismatch: expected %0h, actual %0h", exp_r.bus_byte, out_if.bus_byte);
      err_count++;
    end
    if (out_if.is_data !== exp_r.is_data) begin
      $error("is_data mismatch: expected %0d, actual %0d", exp_r.is_data, out_if.is_data);
      err_count++;
    end
    if (out_if.status !== exp_r.status) begin
      $error("status mismatch: expected %0d, actual %0d", exp_r.status, out_if.status);
      err_count++;
    end
    if (out_if.last !== exp_r.last) begin
      $error("last mismatch: expected %0d, actual %0d", exp_r.last, out_if.last);
      err_count++;
    end
  endfunction

  // Prediction, checking and the watchdog all run on the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      page_reg     = '0;
      column_reg   = '0;
      width_reg    = 8'd128;
      count_reg    = '0;
      blk_open     = 1'b0;
      sent_cnt     = '0;
      col_pos      = '0;
      row_pos      = '0;
      quiet_cycles = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_START_PAGE:   page_reg = cfg_if.data[2:0];
          CFG_START_COLUMN: column_reg = cfg_if.data[6:0];
          CFG_ROW_WIDTH:    width_reg = cfg_if.data[7:0];
          CFG_BYTE_COUNT:   count_reg = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) predict_bus_bytes(in_if.pixel_byte);
      if (out_if.valid && out_if.ready) check_bus_byte();
      if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_pixel(input logic [7:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.pixel_byte = pix;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent_tb++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (bus_exp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [9:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_config(input logic [9:0] page, input logic [9:0] column,
                            input logic [9:0] width, input logic [9:0] count);
    wait_idle();
    write_reg(CFG_START_PAGE, page);
    write_reg(CFG_START_COLUMN, column);
    write_reg(CFG_ROW_WIDTH, width);
    write_reg(CFG_BYTE_COUNT, count);
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  task automatic test_dropped_bytes();
    set_config(10'd0, 10'd0, 10'd0, 10'd2);
    send_pixel(8'hA5);
    send_pixel(8'h5A);
    set_config(10'd7, 10'd127, 10'd1, 10'd10);
    for (int i = 0; i < 10; i++) send_pixel(8'(8'h11 * i));
  endtask

  task automatic test_oversized_blocks();
    set_config(10'd2, 10'd5, 10'd3, 10'd513);
    send_pixel(8'h3C);
    set_config(10'd2, 10'd5, 10'd3, 10'd1023);
    send_pixel(8'hC3);
    set_config(10'd1, 10'd64, 10'd255, 10'd512);
    for (int i = 0; i < 3; i++) send_pixel(8'($urandom_range(255)));
    set_config(10'd1, 10'd64, 10'd255, 10'd4);
    send_pixel(8'h55);
    send_pixel(8'hAA);
  endtask

  task automatic test_register_upper_bits();
    set_config(10'h3F8 | 10'd5, 10'h380 | 10'd9, 10'h300 | 10'd16, 10'd3);
    for (int i = 0; i < 3; i++) send_pixel(8'($urandom_range(255)));
  endtask

  task automatic test_output_stall();
    set_config(10'd3, 10'd40, 10'd6, 10'd20);
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_cycles = 200;
    @(negedge clk);
    for (int i = 0; i < 20; i++) send_pixel(8'($urandom_range(255)));
  endtask

  task automatic run_random_block();
    int r;
    int n;
    logic [9:0] page;
    logic [9:0] column;
    logic [9:0] width;
    logic [9:0] count;
    page   = 10'($urandom_range(7));
    column = 10'($urandom_range(127));
    r = $urandom_range(99);
    if (r < 8) width = 10'd0;
    else if (r < 16) width = 10'($urandom_range(255, 129));
    else if (r < 24) width = 10'd128;
    else width = 10'($urandom_range(12, 1));
    r = $urandom_range(99);
    if (r < 10) count = 10'($urandom_range(1023, PANEL_BYTES + 1));
    else if (r < 15) count = 10'd0;
    else if (r < 20) count = 10'($urandom_range(PANEL_BYTES, 100));
    else count = 10'($urandom_range(40, 1));
    if ($urandom_range(7) == 0) begin
      page   = page | 10'($urandom_range(127) << 3);
      column = column | 10'($urandom_range(7) << 7);
      width  = width | 10'($urandom_range(3) << 8);
    end
    set_config(page, column, width, count);
    if (int'(count) > PANEL_BYTES) begin
      n = $urandom_range(3, 1);
    end else begin
      n = (count == 10'd0) ? 1 : int'(count);
      if (n > 40) n = 40;
      if ($urandom_range(4) == 0) n += $urandom_range(5, 1);
    end
    for (int i = 0; i < n; i++) send_pixel(8'($urandom_range(255)));
  endtask

  task automatic run_random_phase(input int idle_pct, input int busy_pct, input int target);
    int stop_at;
    wait_idle();
    send_idle_pct = idle_pct;
    stall_pct = busy_pct;
    stop_at = bytes_sent_tb + target;
    while (bytes_sent_tb < stop_at) run_random_block();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.pixel_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_dropped_bytes();
    test_oversized_blocks();
    test_register_upper_bits();
    test_output_stall();
    run_random_phase(0, 0, 100);
    run_random_phase(66, 0, 100);
    run_random_phase(0, 66, 100);
    run_random_phase(23, 23, 100);

    wait_idle();
    repeat (20) @(negedge clk);
    $display("Sent %0d display bytes over %0d register settings.", bytes_sent_tb,
             settings_used);
    $display("Checked %0d bus bytes, %0d rejected and %0d dropped.", results_seen,
             rejected_seen, dropped_seen);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
